>>> rtl/block_liveness_fixpoint_defines.svh
// Assertion macros used by the checker of the liveness block.
`ifndef BLOCK_LIVENESS_FIXPOINT_DEFINES_SVH
`define BLOCK_LIVENESS_FIXPOINT_DEFINES_SVH

// Same-cycle implication, disabled while reset is low.
`define BLF_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("block_liveness_fixpoint: same-cycle check failed");

// Next-cycle implication, disabled while reset is low.
`define BLF_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("block_liveness_fixpoint: next-cycle check failed");

`endif

>>> rtl/blf_pkg.sv
// Package: constants, record layout and command bundle of the liveness block.
package blf_pkg;

    localparam int MAX_BLOCKS_DEF = 16;
    localparam int NUM_VREGS_DEF  = 64;
    localparam int MAX_SUCCS_DEF  = 2;

    localparam int BIDX_W = 4;   // block index field width
    localparam int SET_W  = 64;  // register set width on the ports
    localparam int CFG_W  = 5;   // block count register width
    localparam int PASS_W = 7;   // pass counter width
    localparam int CMP_W  = 9;   // wide enough for any block count up to 256

    localparam logic [CFG_W-1:0]  BC_RESET   = 5'd16;
    localparam logic [PASS_W-1:0] PASS_LIMIT = 7'd100;

    // One stored block record.
    typedef struct packed {
        logic [SET_W-1:0]  use_set;
        logic [SET_W-1:0]  def_set;
        logic              s1_valid;
        logic [BIDX_W-1:0] s1;
        logic              s2_valid;
        logic [BIDX_W-1:0] s2;
    } t_rec;

    // Commands from the sequencer to the datapath.
    typedef struct packed {
        logic load;      // write the accepted record
        logic clr_live;  // invalidate all live sets
        logic clr_chg;   // clear the change flag
        logic rd_self;   // read record and live sets of the current block
        logic rd_s1;     // latch own sets, read live_in of first successor
        logic rd_s2;     // merge first successor, read live_in of second
        logic upd;       // merge second successor, write back, flag change
    } t_dp_cmd;

endpackage

>>> rtl/blf_datapath.sv
// Datapath: record memory, live set memories and the transfer function.
module blf_datapath #(
    parameter int MAX_BLOCKS = blf_pkg::MAX_BLOCKS_DEF,
    parameter int NUM_VREGS  = blf_pkg::NUM_VREGS_DEF,
    parameter int MAX_SUCCS  = blf_pkg::MAX_SUCCS_DEF,
    localparam int IDX_W = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1,
    localparam int CNT_W = $clog2(MAX_BLOCKS + 1)
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  blf_pkg::t_dp_cmd            i_cmd,
    input  logic [IDX_W-1:0]            i_blk,
    input  logic [CNT_W-1:0]            i_bc,
    input  logic [blf_pkg::BIDX_W-1:0]  i_block_index,
    input  logic [blf_pkg::SET_W-1:0]   i_use_set,
    input  logic [blf_pkg::SET_W-1:0]   i_def_set,
    input  logic                        i_first_succ_valid,
    input  logic [blf_pkg::BIDX_W-1:0]  i_first_succ,
    input  logic                        i_second_succ_valid,
    input  logic [blf_pkg::BIDX_W-1:0]  i_second_succ,
    output logic                        o_chg,
    output logic [blf_pkg::SET_W-1:0]   o_live_in,
    output logic [blf_pkg::SET_W-1:0]   o_live_out
);
    import blf_pkg::*;

    localparam logic [SET_W-1:0] VMASK =
        (NUM_VREGS >= SET_W) ? {SET_W{1'b1}} : ((SET_W'(1) << NUM_VREGS) - SET_W'(1));

    t_rec             rec_mem  [MAX_BLOCKS];
    logic [SET_W-1:0] lin_mem  [MAX_BLOCKS];
    logic [SET_W-1:0] lout_mem [MAX_BLOCKS];

    // One valid bit per block covers both live sets: they are written together.
    logic [MAX_BLOCKS-1:0] r_live_vld;

    t_rec             r_rec_q;
    logic [SET_W-1:0] r_lin_q;
    logic             r_lin_qv;
    logic [SET_W-1:0] r_lout_q;
    logic             r_lout_qv;

    logic [SET_W-1:0] r_acc;
    logic [SET_W-1:0] r_old_in;
    logic [SET_W-1:0] r_old_out;
    logic             r_chg;

    t_rec             wr_rec;
    logic             wr_ok;
    logic             s1_ok;
    logic             s2_ok;
    logic [IDX_W-1:0] lin_addr;
    logic             lin_rd;
    logic [SET_W-1:0] lin_data;
    logic [SET_W-1:0] lout_data;
    logic [SET_W-1:0] new_out;
    logic [SET_W-1:0] new_in;

    always_comb begin
        wr_rec.use_set  = i_use_set & VMASK;
        wr_rec.def_set  = i_def_set & VMASK;
        wr_rec.s1_valid = i_first_succ_valid;
        wr_rec.s1       = i_first_succ;
        wr_rec.s2_valid = i_second_succ_valid;
        wr_rec.s2       = i_second_succ;
        wr_ok = i_cmd.load && (CMP_W'(i_block_index) < CMP_W'(MAX_BLOCKS));
    end

    // Successor takes part only if flagged and inside the active range.
    assign s1_ok = r_rec_q.s1_valid && (CMP_W'(r_rec_q.s1) < CMP_W'(i_bc));
    assign s2_ok = (MAX_SUCCS >= 2) && r_rec_q.s2_valid
                   && (CMP_W'(r_rec_q.s2) < CMP_W'(i_bc));

    always_comb begin
        lin_addr = i_blk;
        if (i_cmd.rd_s1 && s1_ok) begin
            lin_addr = IDX_W'(r_rec_q.s1);
        end else if (i_cmd.rd_s2 && s2_ok) begin
            lin_addr = IDX_W'(r_rec_q.s2);
        end
    end

    assign lin_rd    = i_cmd.rd_self | i_cmd.rd_s1 | i_cmd.rd_s2;
    assign lin_data  = r_lin_qv  ? r_lin_q  : '0;
    assign lout_data = r_lout_qv ? r_lout_q : '0;
    assign new_out   = r_acc | (s2_ok ? lin_data : '0);
    assign new_in    = r_rec_q.use_set | (new_out & ~r_rec_q.def_set);

    // Memories: one write, registered reads.
    always_ff @(posedge i_clk) begin
        if (wr_ok) begin
            rec_mem[IDX_W'(i_block_index)] <= wr_rec;
        end
        if (i_cmd.rd_self) begin
            r_rec_q  <= rec_mem[i_blk];
            r_lout_q <= lout_mem[i_blk];
        end
        if (lin_rd) begin
            r_lin_q <= lin_mem[lin_addr];
        end
        if (i_cmd.upd) begin
            lin_mem[i_blk]  <= new_in;
            lout_mem[i_blk] <= new_out;
        end
    end

    // Working registers of the block step.
    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_s1) begin
            r_old_in  <= lin_data;
            r_old_out <= lout_data;
            r_acc     <= lout_data;
        end else if (i_cmd.rd_s2) begin
            r_acc <= r_acc | (s1_ok ? lin_data : '0);
        end
    end

    // Valid bits and change flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_live_vld <= '0;
            r_lin_qv   <= 1'b0;
            r_lout_qv  <= 1'b0;
            r_chg      <= 1'b0;
        end else begin
            if (i_cmd.clr_live) begin
                r_live_vld <= '0;
            end else if (i_cmd.upd) begin
                r_live_vld[i_blk] <= 1'b1;
            end
            if (lin_rd) begin
                r_lin_qv <= r_live_vld[lin_addr];
            end
            if (i_cmd.rd_self) begin
                r_lout_qv <= r_live_vld[i_blk];
            end
            if (i_cmd.clr_chg) begin
                r_chg <= 1'b0;
            end else if (i_cmd.upd && ((new_out != r_old_out) || (new_in != r_old_in))) begin
                r_chg <= 1'b1;
            end
        end
    end

    assign o_chg      = r_chg;
    assign o_live_in  = lin_data;
    assign o_live_out = lout_data;

endmodule

>>> rtl/blf_ctrl.sv
// Sequencer: load handshake, pass and block counters, result handshake.
module blf_ctrl #(
    parameter int MAX_BLOCKS = blf_pkg::MAX_BLOCKS_DEF,
    localparam int IDX_W = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1,
    localparam int CNT_W = $clog2(MAX_BLOCKS + 1)
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [blf_pkg::CFG_W-1:0]  i_cfg_wdata,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic                       i_last_block,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic                       o_last_result,
    input  logic                       i_chg,
    output blf_pkg::t_dp_cmd           o_cmd,
    output logic [IDX_W-1:0]           o_blk,
    output logic [CNT_W-1:0]           o_bc
);
    import blf_pkg::*;

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_START = 9'b000000010,
        S_RD    = 9'b000000100,
        S_SA    = 9'b000001000,
        S_SB    = 9'b000010000,
        S_UPD   = 9'b000100000,
        S_PEND  = 9'b001000000,
        S_ORD   = 9'b010000000,
        S_OSEND = 9'b100000000
    } t_state;

    t_state              r_state, n_state;
    logic [CFG_W-1:0]    r_cfg;
    logic [CNT_W-1:0]    r_bc, n_bc;
    logic [IDX_W-1:0]    r_blk, n_blk;
    logic [PASS_W-1:0]   r_pass, n_pass;
    logic [CNT_W-1:0]    bc_sat;
    logic                is_last;

    // Saturate the configured count to the store depth.
    assign bc_sat  = (CMP_W'(r_cfg) > CMP_W'(MAX_BLOCKS)) ? CNT_W'(MAX_BLOCKS)
                                                          : CNT_W'(r_cfg);
    assign is_last = (CNT_W'(r_blk) == (r_bc - CNT_W'(1)));

    always_comb begin
        n_state = r_state;
        n_bc    = r_bc;
        n_blk   = r_blk;
        n_pass  = r_pass;
        o_cmd   = '0;
        o_ready = 1'b0;
        o_valid = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_ready   = 1'b1;
                o_cmd.load = i_valid;
                if (i_valid && i_last_block) begin
                    n_state = S_START;
                end
            end
            S_START: begin
                o_cmd.clr_live = 1'b1;
                o_cmd.clr_chg  = 1'b1;
                n_bc           = bc_sat;
                n_pass         = PASS_W'(1);
                n_blk          = IDX_W'(bc_sat - CNT_W'(1));
                n_state        = (bc_sat == '0) ? S_IDLE : S_RD;
            end
            S_RD: begin
                o_cmd.rd_self = 1'b1;
                n_state       = S_SA;
            end
            S_SA: begin
                o_cmd.rd_s1 = 1'b1;
                n_state     = S_SB;
            end
            S_SB: begin
                o_cmd.rd_s2 = 1'b1;
                n_state     = S_UPD;
            end
            S_UPD: begin
                o_cmd.upd = 1'b1;
                if (r_blk == '0) begin
                    n_state = S_PEND;
                end else begin
                    n_blk   = r_blk - IDX_W'(1);
                    n_state = S_RD;
                end
            end
            S_PEND: begin
                if (i_chg && (r_pass < PASS_LIMIT)) begin
                    o_cmd.clr_chg = 1'b1;
                    n_pass        = r_pass + PASS_W'(1);
                    n_blk         = IDX_W'(r_bc - CNT_W'(1));
                    n_state       = S_RD;
                end else begin
                    n_blk   = '0;
                    n_state = S_ORD;
                end
            end
            S_ORD: begin
                o_cmd.rd_self = 1'b1;
                n_state       = S_OSEND;
            end
            S_OSEND: begin
                o_valid = 1'b1;
                if (i_ready) begin
                    if (is_last) begin
                        n_state = S_IDLE;
                    end else begin
                        n_blk   = r_blk + IDX_W'(1);
                        n_state = S_ORD;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cfg   <= BC_RESET;
            r_bc    <= '0;
            r_blk   <= '0;
            r_pass  <= '0;
        end else begin
            r_state <= n_state;
            r_bc    <= n_bc;
            r_blk   <= n_blk;
            r_pass  <= n_pass;
            if (i_cfg_we) begin
                r_cfg <= i_cfg_wdata;
            end
        end
    end

    assign o_last_result = is_last;
    assign o_blk         = r_blk;
    assign o_bc          = r_bc;

endmodule

>>> rtl/block_liveness_fixpoint.sv
// Top level of the backward liveness fixpoint engine.
//
// Load one record beat per basic block (use set, def set, up to two
// successors). The beat flagged last_block starts the analysis over
// blocks 0 .. N-1, N being the configured block count (it saturates at
// MAX_BLOCKS; a count of zero returns to idle with no results). All live
// sets are invalidated at once, then passes sweep from the highest block
// down to block 0: the live-out set picks up the current live-in set of
// each valid successor and the live-in set becomes use | (live-out & ~def),
// every update seen at once by later blocks. Passes repeat until one
// changes nothing, or 100 passes have run. Each block step reads the
// live-in memory through its single read port (own entry, then each
// successor in turn), then writes back. Results then leave in ascending
// block order, one beat per block; each beat is read from the stores
// before it is offered, and the next only after the last is taken;
// converged is the same on every beat and last_result marks the beat of
// block N-1. No new record is taken from the start of the analysis until
// the last result beat is gone. Stored records persist across runs until
// overwritten; a block never loaded gives undefined results. Write the
// block count only while idle.
module block_liveness_fixpoint #(
    parameter int MAX_BLOCKS = blf_pkg::MAX_BLOCKS_DEF,
    parameter int NUM_VREGS  = blf_pkg::NUM_VREGS_DEF,
    parameter int MAX_SUCCS  = blf_pkg::MAX_SUCCS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // configuration
    input  logic                        i_cfg_we,
    input  logic [blf_pkg::CFG_W-1:0]   i_cfg_wdata,
    // record beats
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [blf_pkg::BIDX_W-1:0]  i_block_index,
    input  logic [blf_pkg::SET_W-1:0]   i_use_set,
    input  logic [blf_pkg::SET_W-1:0]   i_def_set,
    input  logic                        i_first_succ_valid,
    input  logic [blf_pkg::BIDX_W-1:0]  i_first_succ,
    input  logic                        i_second_succ_valid,
    input  logic [blf_pkg::BIDX_W-1:0]  i_second_succ,
    input  logic                        i_last_block,
    // result beats
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [blf_pkg::BIDX_W-1:0]  o_out_block,
    output logic [blf_pkg::SET_W-1:0]   o_live_in,
    output logic [blf_pkg::SET_W-1:0]   o_live_out,
    output logic                        o_converged,
    output logic                        o_last_result
);
    import blf_pkg::*;

    localparam int IDX_W = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int CNT_W = $clog2(MAX_BLOCKS + 1);

    t_dp_cmd          dp_cmd;
    logic [IDX_W-1:0] blk;
    logic [CNT_W-1:0] bc;
    logic             chg;

    // Sequencer: owns the handshakes, counters and the block count register.
    blf_ctrl #(
        .MAX_BLOCKS (MAX_BLOCKS)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_last_block  (i_last_block),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_last_result (o_last_result),
        .i_chg         (chg),
        .o_cmd         (dp_cmd),
        .o_blk         (blk),
        .o_bc          (bc)
    );

    // Datapath: stores and the per-block transfer function.
    blf_datapath #(
        .MAX_BLOCKS (MAX_BLOCKS),
        .NUM_VREGS  (NUM_VREGS),
        .MAX_SUCCS  (MAX_SUCCS)
    ) u_dp (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cmd               (dp_cmd),
        .i_blk               (blk),
        .i_bc                (bc),
        .i_block_index       (i_block_index),
        .i_use_set           (i_use_set),
        .i_def_set           (i_def_set),
        .i_first_succ_valid  (i_first_succ_valid),
        .i_first_succ        (i_first_succ),
        .i_second_succ_valid (i_second_succ_valid),
        .i_second_succ       (i_second_succ),
        .o_chg               (chg),
        .o_live_in           (o_live_in),
        .o_live_out          (o_live_out)
    );

    // Converged when the final pass left every set unchanged.
    assign o_converged = ~chg;
    assign o_out_block = BIDX_W'(blk);

endmodule

>>> rtl/blf_checker.sv
// Port-level checker of the liveness block, bound to the top level.
`include "block_liveness_fixpoint_defines.svh"

module blf_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        o_ready,
    input logic                        o_valid,
    input logic                        i_ready,
    input logic [blf_pkg::BIDX_W-1:0]  o_out_block,
    input logic [blf_pkg::SET_W-1:0]   o_live_in,
    input logic [blf_pkg::SET_W-1:0]   o_live_out,
    input logic                        o_converged,
    input logic                        o_last_result
);

    // Hold a stalled result beat.
    `BLF_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_valid && !i_ready, o_valid && $stable(o_out_block) && $stable(o_live_in) && $stable(o_live_out) && $stable(o_last_result))

    // No record is taken while results drain.
    `BLF_ASSERT_IMP(a_no_load_in_drain, i_clk, i_rst_n, o_valid, !o_ready)

    // After the final beat, drop back to loading.
    `BLF_ASSERT_NXT(a_last_ends, i_clk, i_rst_n, o_valid && i_ready && o_last_result, !o_valid && o_ready)

    // Advance one block per beat, converged flag steady.
    `BLF_ASSERT_NXT(a_next_block, i_clk, i_rst_n, o_valid && i_ready && !o_last_result, !o_valid ##1 (o_valid && (o_out_block == $past(o_out_block, 2) + 4'd1) && (o_converged == $past(o_converged, 2))))

endmodule

bind block_liveness_fixpoint blf_checker u_blf_checker (.*);
